### rtl/pitch_to_note_and_cents_top_macros.svh
// Assertion macros shared by the pitch to note and cents RTL.
`ifndef PITCH_TO_NOTE_AND_CENTS_TOP_MACROS_SVH
`define PITCH_TO_NOTE_AND_CENTS_TOP_MACROS_SVH

// check cons in the same cycle as ante
`define PTNC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ptnc assertion failed");

// check cons in the cycle after ante
`define PTNC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ptnc assertion failed");

`endif

### rtl/ptnc_pkg.sv
// Shared constants, types and helper functions for the pitch to note converter.
package ptnc_pkg;

   localparam int LOG_FRACTION_BITS_DEFAULT = 16;

   localparam int PITCH_W   = 16;
   localparam int EXP_W     = 4;
   localparam int MANT_W    = 32;
   localparam int NMAG_W    = 8;
   localparam int NOTE_W    = 4;
   localparam int CENTS_W   = 7;
   localparam int DATA_W    = 16;
   localparam int RSP_W     = 16;

   localparam logic [PITCH_W-1:0] REF_RESET      = 16'd7040;
   localparam logic [NOTE_W-1:0]  SEMIS_PER_OCT  = 4'd12;
   localparam logic [6:0]         CENTS_PER_SEMI = 7'd100;
   localparam logic [7:0]         MOD12_RECIP    = 8'd171;

   typedef struct packed {
      logic valid;
      logic live;
   } ctl_type;

   function automatic logic [EXP_W-1:0] msb_index(input logic [PITCH_W-1:0] v);
      logic [EXP_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < PITCH_W; i++) begin
         if (v[i]) idx = EXP_W'(i);
      end
      return idx;
   endfunction

   // valid for values up to 192
   function automatic logic [NOTE_W-1:0] mod12(input logic [NMAG_W-1:0] n);
      logic [15:0] prod;
      logic [4:0]  q;
      logic [NMAG_W-1:0] r;
      prod = 16'(n) * 16'(MOD12_RECIP);
      q    = prod[15:11];
      r    = n - (NMAG_W'(q) * NMAG_W'(SEMIS_PER_OCT));
      return r[NOTE_W-1:0];
   endfunction

endpackage

### rtl/ptnc_norm.sv
// Normalize pitch and reference into exponent and Q1.31 mantissa.
module ptnc_norm (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  ptnc_pkg::ctl_type                ctl_in,
   input  logic [ptnc_pkg::PITCH_W-1:0]     pitch,
   input  logic [ptnc_pkg::PITCH_W-1:0]     ref_pitch,
   output ptnc_pkg::ctl_type                ctl_out,
   output logic [ptnc_pkg::EXP_W-1:0]       e_p,
   output logic [ptnc_pkg::MANT_W-1:0]      m_p,
   output logic [ptnc_pkg::EXP_W-1:0]       e_r,
   output logic [ptnc_pkg::MANT_W-1:0]      m_r
);

   localparam logic [4:0] MANT_TOP = 5'(ptnc_pkg::MANT_W - 1);

   ptnc_pkg::ctl_type                ctl_ff;
   logic [ptnc_pkg::EXP_W-1:0]       e_p_ff, e_r_ff, e_p_in, e_r_in;
   logic [ptnc_pkg::MANT_W-1:0]      m_p_ff, m_r_ff, m_p_in, m_r_in;

   always_comb begin
      e_p_in = ptnc_pkg::msb_index(pitch);
      e_r_in = ptnc_pkg::msb_index(ref_pitch);
      m_p_in = ptnc_pkg::MANT_W'(pitch) << (MANT_TOP - 5'(e_p_in));
      m_r_in = ptnc_pkg::MANT_W'(ref_pitch) << (MANT_TOP - 5'(e_r_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_p_ff <= e_p_in;
         e_r_ff <= e_r_in;
         m_p_ff <= m_p_in;
         m_r_ff <= m_r_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign e_p     = e_p_ff;
   assign m_p     = m_p_ff;
   assign e_r     = e_r_ff;
   assign m_r     = m_r_ff;

endmodule

### rtl/ptnc_log_step.sv
// One squaring step of the log2 fraction for pitch and reference lanes.
module ptnc_log_step #(
   parameter int LOG_FRACTION_BITS = ptnc_pkg::LOG_FRACTION_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  ptnc_pkg::ctl_type                ctl_in,
   input  logic [ptnc_pkg::EXP_W-1:0]       e_p,
   input  logic [ptnc_pkg::MANT_W-1:0]      m_p,
   input  logic [LOG_FRACTION_BITS-1:0]     frac_p,
   input  logic [ptnc_pkg::EXP_W-1:0]       e_r,
   input  logic [ptnc_pkg::MANT_W-1:0]      m_r,
   input  logic [LOG_FRACTION_BITS-1:0]     frac_r,
   output ptnc_pkg::ctl_type                ctl_out,
   output logic [ptnc_pkg::EXP_W-1:0]       e_p_out,
   output logic [ptnc_pkg::MANT_W-1:0]      m_p_out,
   output logic [LOG_FRACTION_BITS-1:0]     frac_p_out,
   output logic [ptnc_pkg::EXP_W-1:0]       e_r_out,
   output logic [ptnc_pkg::MANT_W-1:0]      m_r_out,
   output logic [LOG_FRACTION_BITS-1:0]     frac_r_out
);

   localparam int MW = ptnc_pkg::MANT_W;
   localparam int F  = LOG_FRACTION_BITS;

   ptnc_pkg::ctl_type          ctl_ff;
   logic [ptnc_pkg::EXP_W-1:0] e_p_ff, e_r_ff;
   logic [MW-1:0]              m_p_ff, m_r_ff, m_p_in, m_r_in;
   logic [F-1:0]               frac_p_ff, frac_r_ff, frac_p_in, frac_r_in;
   logic [2*MW-1:0]            sq_p, sq_r;
   logic [MW:0]                t_p, t_r;

   always_comb begin
      sq_p      = (2*MW)'(m_p) * (2*MW)'(m_p);
      sq_r      = (2*MW)'(m_r) * (2*MW)'(m_r);
      t_p       = sq_p[2*MW-1:MW-1];
      t_r       = sq_r[2*MW-1:MW-1];
      m_p_in    = t_p[MW] ? t_p[MW:1] : t_p[MW-1:0];
      m_r_in    = t_r[MW] ? t_r[MW:1] : t_r[MW-1:0];
      frac_p_in = {frac_p[F-2:0], t_p[MW]};
      frac_r_in = {frac_r[F-2:0], t_r[MW]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_p_ff    <= e_p;
         e_r_ff    <= e_r;
         m_p_ff    <= m_p_in;
         m_r_ff    <= m_r_in;
         frac_p_ff <= frac_p_in;
         frac_r_ff <= frac_r_in;
      end
   end

   assign ctl_out    = ctl_ff;
   assign e_p_out    = e_p_ff;
   assign m_p_out    = m_p_ff;
   assign frac_p_out = frac_p_ff;
   assign e_r_out    = e_r_ff;
   assign m_r_out    = m_r_ff;
   assign frac_r_out = frac_r_ff;

endmodule

### rtl/ptnc_finish.sv
// Semitone offset, rounding, note index and cents over three stages.
module ptnc_finish #(
   parameter int LOG_FRACTION_BITS = ptnc_pkg::LOG_FRACTION_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  ptnc_pkg::ctl_type                ctl_in,
   input  logic [ptnc_pkg::EXP_W-1:0]       e_p,
   input  logic [LOG_FRACTION_BITS-1:0]     frac_p,
   input  logic [ptnc_pkg::EXP_W-1:0]       e_r,
   input  logic [LOG_FRACTION_BITS-1:0]     frac_r,
   output ptnc_pkg::ctl_type                ctl_out,
   output logic [ptnc_pkg::NOTE_W-1:0]      note_index,
   output logic [ptnc_pkg::CENTS_W-1:0]     cents
);

   localparam int F   = LOG_FRACTION_BITS;
   localparam int LW  = F + ptnc_pkg::EXP_W;
   localparam int SW  = F + ptnc_pkg::NMAG_W;
   localparam int CW  = F + ptnc_pkg::CENTS_W;
   localparam int NW  = ptnc_pkg::NMAG_W;
   localparam int TW  = ptnc_pkg::NOTE_W;
   localparam int KW  = ptnc_pkg::CENTS_W;

   // stage A: log difference
   ptnc_pkg::ctl_type ctl_a_ff;
   logic              neg_a_ff, neg_a_in;
   logic [LW-1:0]     dmag_a_ff, dmag_a_in, lp, lr;

   // stage B: scale by twelve and round
   ptnc_pkg::ctl_type ctl_b_ff;
   logic              neg_b_ff, rneg_b_ff, rneg_b_in;
   logic [NW-1:0]     nmag_b_ff, nmag_b_in;
   logic [F-1:0]      ra_b_ff, ra_b_in, low;
   logic [SW-1:0]     smag;
   logic [NW:0]       nsum;
   logic [F:0]        rdiff;

   // stage C: note and cents
   ptnc_pkg::ctl_type ctl_c_ff;
   logic [TW-1:0]     note_c_ff, note_c_in, note_raw;
   logic [KW-1:0]     cents_c_ff, cents_c_in, cmag;
   logic [CW-1:0]     csum;
   logic              cneg;

   always_comb begin
      lp        = {e_p, frac_p};
      lr        = {e_r, frac_r};
      neg_a_in  = lp < lr;
      dmag_a_in = neg_a_in ? (lr - lp) : (lp - lr);
   end

   always_comb begin
      smag      = (SW'(dmag_a_ff) << 3) + (SW'(dmag_a_ff) << 2);
      low       = smag[F-1:0];
      rneg_b_in = smag[F-1];
      nsum      = (NW+1)'(smag[SW-1:F]) + (NW+1)'(rneg_b_in);
      nmag_b_in = nsum[NW-1:0];
      rdiff     = ((F+1)'(1) << F) - (F+1)'(low);
      ra_b_in   = rneg_b_in ? rdiff[F-1:0] : low;
   end

   always_comb begin
      csum     = CW'(ra_b_ff) * CW'(ptnc_pkg::CENTS_PER_SEMI)
               + (CW'(1) << (F - 1));
      cmag     = csum[CW-1:F];
      cneg     = (rneg_b_ff != neg_b_ff) && (cmag != '0);
      note_raw = ptnc_pkg::mod12(nmag_b_ff);
      if (neg_b_ff && note_raw != '0) begin
         note_raw = ptnc_pkg::SEMIS_PER_OCT - note_raw;
      end
      cents_c_in = cneg ? (KW'(0) - cmag) : cmag;
      note_c_in  = note_raw;
      if (!ctl_b_ff.live) begin
         cents_c_in = '0;
         note_c_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
         ctl_c_ff <= '0;
      end else if (en) begin
         ctl_a_ff <= ctl_in;
         ctl_b_ff <= ctl_a_ff;
         ctl_c_ff <= ctl_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_a_ff   <= neg_a_in;
         dmag_a_ff  <= dmag_a_in;
         neg_b_ff   <= neg_a_ff;
         rneg_b_ff  <= rneg_b_in;
         nmag_b_ff  <= nmag_b_in;
         ra_b_ff    <= ra_b_in;
         note_c_ff  <= note_c_in;
         cents_c_ff <= cents_c_in;
      end
   end

   assign ctl_out    = ctl_c_ff;
   assign note_index = note_c_ff;
   assign cents      = cents_c_ff;

endmodule

### rtl/pitch_to_note_and_cents_top.sv
// Pitch to note and cents converter: top level with input, pipeline and output skid.
//
// Usage:
//   req channel carries one pitch word (unsigned Q12.4 Hz) per handshake.
//   rsp channel returns one word per request: note index and cents in tdata,
//   pitch_valid in tuser. A zero pitch or zero reference gives pitch_valid 0
//   with note and cents zero.
//   csr_wr_en / csr_wr_data write the reference pitch (note zero); write only
//   while no request is in flight.
// Pipeline: one input register, one normalize stage, one squaring stage per
//   log2 fraction bit, three finishing stages, then the output register.
// Throughput: one word per cycle while req_tready is high, with one 32x32
//   multiplier per lane in each squaring stage.
// Reset: clears all valid bits and loads the reference pitch with 440 Hz.
// Stall: when rsp_tready is low the pipeline keeps running until the output
//   register and the skid register both hold a word; req_tready then drops
//   until the output drains. No word is lost or repeated.
`include "pitch_to_note_and_cents_top_macros.svh"

module pitch_to_note_and_cents_top #(
   parameter int LOG_FRACTION_BITS = ptnc_pkg::LOG_FRACTION_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,   // reference_pitch
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,     // [15:0] pitch
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,     // [3:0] note_index, [10:4] cents, [15:11] zero
   output logic [0:0]  rsp_tuser      // [0] pitch_valid
);

   localparam int F  = LOG_FRACTION_BITS;
   localparam int PW = ptnc_pkg::PITCH_W;
   localparam int EW = ptnc_pkg::EXP_W;
   localparam int MW = ptnc_pkg::MANT_W;
   localparam int TW = ptnc_pkg::NOTE_W;
   localparam int KW = ptnc_pkg::CENTS_W;
   localparam int OW = 1 + TW + KW;

   logic              en;
   logic [PW-1:0]     ref_ff;

   ptnc_pkg::ctl_type in_ctl_ff, in_ctl_in;
   logic [PW-1:0]     in_pitch_ff, in_ref_ff;

   ptnc_pkg::ctl_type ctl_s    [F+1];
   logic [EW-1:0]     e_p_s    [F+1];
   logic [MW-1:0]     m_p_s    [F+1];
   logic [F-1:0]      frac_p_s [F+1];
   logic [EW-1:0]     e_r_s    [F+1];
   logic [MW-1:0]     m_r_s    [F+1];
   logic [F-1:0]      frac_r_s [F+1];

   ptnc_pkg::ctl_type tail_ctl;
   logic [TW-1:0]     tail_note;
   logic [KW-1:0]     tail_cents;
   logic [OW-1:0]     tail_word;

   logic              out_v_ff, out_v_in, skid_v_ff, skid_v_in;
   logic [OW-1:0]     out_word_ff, out_word_in, skid_word_ff, skid_word_in;
   logic              take, tail_v;
   logic signed [KW-1:0] out_cents;

   assign en         = !skid_v_ff;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= ptnc_pkg::REF_RESET;
      end else if (csr_wr_en) begin
         ref_ff <= csr_wr_data;
      end
   end

   always_comb begin
      in_ctl_in.valid = req_tvalid;
      in_ctl_in.live  = (req_tdata != '0) && (ref_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ctl_ff <= '0;
      end else if (en) begin
         in_ctl_ff <= in_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_pitch_ff <= req_tdata;
         in_ref_ff   <= ref_ff;
      end
   end

   ptnc_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .ctl_in    (in_ctl_ff),
      .pitch     (in_pitch_ff),
      .ref_pitch (in_ref_ff),
      .ctl_out   (ctl_s[0]),
      .e_p       (e_p_s[0]),
      .m_p       (m_p_s[0]),
      .e_r       (e_r_s[0]),
      .m_r       (m_r_s[0])
   );

   assign frac_p_s[0] = '0;
   assign frac_r_s[0] = '0;

   for (genvar k = 0; k < F; k++) begin : g_step
      ptnc_log_step #(
         .LOG_FRACTION_BITS (F)
      ) u_step (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .ctl_in     (ctl_s[k]),
         .e_p        (e_p_s[k]),
         .m_p        (m_p_s[k]),
         .frac_p     (frac_p_s[k]),
         .e_r        (e_r_s[k]),
         .m_r        (m_r_s[k]),
         .frac_r     (frac_r_s[k]),
         .ctl_out    (ctl_s[k+1]),
         .e_p_out    (e_p_s[k+1]),
         .m_p_out    (m_p_s[k+1]),
         .frac_p_out (frac_p_s[k+1]),
         .e_r_out    (e_r_s[k+1]),
         .m_r_out    (m_r_s[k+1]),
         .frac_r_out (frac_r_s[k+1])
      );
   end

   ptnc_finish #(
      .LOG_FRACTION_BITS (F)
   ) u_finish (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .ctl_in     (ctl_s[F]),
      .e_p        (e_p_s[F]),
      .frac_p     (frac_p_s[F]),
      .e_r        (e_r_s[F]),
      .frac_r     (frac_r_s[F]),
      .ctl_out    (tail_ctl),
      .note_index (tail_note),
      .cents      (tail_cents)
   );

   assign tail_word = {tail_cents, tail_note, tail_ctl.live};
   assign tail_v    = en && tail_ctl.valid;
   assign take      = !out_v_ff || rsp_tready;

   // advance into the output register, park in skid when output is stalled
   always_comb begin
      out_v_in     = out_v_ff;
      out_word_in  = out_word_ff;
      skid_v_in    = skid_v_ff;
      skid_word_in = skid_word_ff;
      if (take) begin
         if (skid_v_ff) begin
            out_v_in     = 1'b1;
            out_word_in  = skid_word_ff;
            skid_v_in    = tail_v;
            skid_word_in = tail_word;
         end else begin
            out_v_in     = tail_v;
            out_word_in  = tail_word;
         end
      end else if (tail_v) begin
         skid_v_in    = 1'b1;
         skid_word_in = tail_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_word_ff[0:0];
   assign rsp_tdata  = ptnc_pkg::RSP_W'(out_word_ff[OW-1:1]);
   assign out_cents  = out_word_ff[OW-1:TW+1];

   `PTNC_ASSERT_NOW(a_skid_implies_out, skid_v_ff, out_v_ff)
   `PTNC_ASSERT_NEXT(a_skid_kept_on_stall, skid_v_ff && !rsp_tready, skid_v_ff)
   `PTNC_ASSERT_NOW(a_invalid_word_zero, out_v_ff && !out_word_ff[0], out_word_ff[OW-1:1] == '0)
   `PTNC_ASSERT_NOW(a_note_range, out_v_ff, out_word_ff[TW:1] < ptnc_pkg::SEMIS_PER_OCT)
   `PTNC_ASSERT_NOW(a_cents_range, out_v_ff, (out_cents <= 7'sd50) && (out_cents >= -7'sd50))

endmodule
